// ===== src/hole_point_containment_test_defines.svh =====
`ifndef HOLE_POINT_CONTAINMENT_TEST_DEFINES_SVH
`define HOLE_POINT_CONTAINMENT_TEST_DEFINES_SVH
// assertion helpers
`define HPCT_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define HPCT_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ===== src/hpct_pkg.sv =====
package hpct_pkg;
    localparam int NUM_HOLES = 16;
    localparam int FRAC_BITS = 16;
    localparam int SLOT_W = 4;
    localparam int ROWS = 3;
    localparam int MEM_DEPTH = NUM_HOLES * ROWS * 4;
    localparam int MEM_AW = $clog2(MEM_DEPTH);
    localparam int ACC_W = 68;

    typedef enum logic [1:0] {
        FUNC_CLEAR = 2'd0,
        FUNC_LOAD  = 2'd1,
        FUNC_QUERY = 2'd2,
        FUNC_NOP   = 2'd3
    } func_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_HOLE,
        ST_RD_D,
        ST_MUL,
        ST_ROW_END,
        ST_SQ,
        ST_SQ_ACC,
        ST_DECIDE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic          clr;
        logic          ld_d;
        logic          ld_prod;
        logic          sq_acc;
    } dp_ctrl_t;
endpackage

// ===== src/hpct_mac.sv =====
module hpct_mac
    import hpct_pkg::*;
(
    input  logic                     aclk,
    input  dp_ctrl_t                 ctrl,
    input  logic signed [31:0]       mul_a,
    input  logic signed [33:0]       mul_b,
    output logic signed [ACC_W-1:0]  acc,
    output logic        [ACC_W-1:0]  sq_sum
);
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic        [ACC_W-1:0] sq_reg, sq_next;
    logic signed [65:0]      prod;
    logic signed [65:0]      prod_reg;

    assign prod = mul_a * mul_b;

    always_ff @(posedge aclk) begin
        prod_reg <= prod;
        acc_reg  <= acc_next;
        sq_reg   <= sq_next;
    end

    always_comb begin
        acc_next = acc_reg;
        sq_next  = sq_reg;
        if (ctrl.clr) begin
            sq_next = '0;
        end
        if (ctrl.ld_d) begin
            acc_next = ACC_W'(mul_a);
        end
        if (ctrl.ld_prod) begin
            acc_next = acc_reg + ACC_W'(prod_reg >>> FRAC_BITS);
        end
        if (ctrl.sq_acc) begin
            sq_next = sq_reg + ACC_W'(prod_reg);
        end
    end

    assign acc    = acc_reg;
    assign sq_sum = sq_reg;
endmodule

// ===== src/hole_point_containment_test.sv =====
// Hole containment test. A clear, a no-op or a load to row 3 goes straight to the
// output state; a load to rows 0 to 2 writes four words, then raises its result.
// A query (func 2) walks the valid holes in slot order through one shared
// 32x34 multiplier: an invalid slot is skipped; a valid hole starts, then per
// used row does a translation fetch, a multiply and an add per term and a range
// check, then squares each component for round holes and decides; a row out of
// range goes straight to the decision. The query stops at the first hit.
// One transaction at a time; the result waits in an output register.
`include "hole_point_containment_test_defines.svh"
module hole_point_containment_test
    import hpct_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_func,
    input  logic [3:0]          s_slot,
    input  logic [1:0]          s_row,
    input  logic signed [31:0]  s_coef_a,
    input  logic signed [31:0]  s_coef_b,
    input  logic signed [31:0]  s_coef_c,
    input  logic signed [31:0]  s_coef_d,
    input  logic                s_round_shape,
    input  logic                s_solid_shape,
    input  logic signed [31:0]  s_point_x,
    input  logic signed [31:0]  s_point_y,
    input  logic signed [31:0]  s_point_z,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_hit,
    output logic [3:0]          m_hit_slot
);
    localparam logic signed [ACC_W-1:0] ONE = ACC_W'(1) <<< FRAC_BITS;
    localparam logic [ACC_W-1:0] ONE_SQ = ACC_W'(1) << (2 * FRAC_BITS);

    state_t state_reg, state_next;
    logic [31:0] mem [MEM_DEPTH];
    logic [31:0] rd_reg;
    logic [MEM_AW-1:0] rd_addr;
    logic [MEM_AW-1:0] wr_base;
    logic [1:0] rd_row;

    logic [NUM_HOLES-1:0] valid_reg, round_reg, solid_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [1:0] row_reg, term_reg;
    logic term_phase_reg;
    logic signed [31:0] px_reg, py_reg, pz_reg;
    logic hit_reg, m_valid_reg;
    logic [SLOT_W-1:0] hit_slot_reg;
    logic reject_reg;
    logic signed [ACC_W-1:0] comp_reg [ROWS];
    logic [1:0] ld_word_reg;

    dp_ctrl_t ctrl;
    logic signed [31:0] mul_a;
    logic signed [33:0] mul_b;
    logic signed [ACC_W-1:0] acc;
    logic [ACC_W-1:0] sq_sum;
    logic solid_cur, last_row, accept, out_fire;
    logic [1:0] used_rows;

    assign accept   = s_valid && s_ready;
    assign out_fire = m_valid_reg && m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && !m_valid_reg;
    assign solid_cur = solid_reg[slot_reg];
    assign used_rows = solid_cur ? 2'd3 : 2'd2;
    assign last_row  = (row_reg == used_rows - 2'd1);

    hpct_mac u_mac (
        .aclk   (aclk),
        .ctrl   (ctrl),
        .mul_a  (mul_a),
        .mul_b  (mul_b),
        .acc    (acc),
        .sq_sum (sq_sum)
    );

    // coefficient store, word order a b c d per row
    logic [31:0] wr_a, wr_b, wr_c, wr_d;
    always_ff @(posedge aclk) begin
        if (accept && s_func == FUNC_LOAD && s_row != 2'd3) begin
            wr_a <= s_coef_a;
            wr_b <= s_coef_b;
            wr_c <= s_coef_c;
            wr_d <= s_coef_d;
        end
        if (state_reg == ST_LOAD) begin
            case (ld_word_reg)
                2'd0: mem[wr_base] <= wr_a;
                2'd1: mem[wr_base + MEM_AW'(1)] <= wr_b;
                2'd2: mem[wr_base + MEM_AW'(2)] <= wr_c;
                default: mem[wr_base + MEM_AW'(3)] <= wr_d;
            endcase
        end
        rd_reg <= mem[rd_addr];
    end

    // registered fetch: each word is read in the cycle before it is used
    always_comb begin
        rd_row = row_reg;
        if (state_reg == ST_HOLE) rd_row = 2'd0;
        else if (state_reg == ST_ROW_END && !last_row) rd_row = row_reg + 2'd1;
        rd_addr = MEM_AW'((32'(slot_reg) * ROWS + 32'(rd_row)) * 4);
        case (state_reg)
            ST_HOLE, ST_ROW_END: rd_addr = rd_addr + MEM_AW'(3);
            ST_RD_D: rd_addr = rd_addr + MEM_AW'(term_reg);
            ST_MUL: rd_addr = rd_addr + MEM_AW'(term_reg) + MEM_AW'(term_phase_reg);
            default: ;
        endcase
    end
    assign wr_base = MEM_AW'((32'(slot_reg) * ROWS + 32'(row_reg)) * 4);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_func)
                        FUNC_LOAD:
                            state_next = (s_row != 2'd3) ? ST_LOAD : ST_OUT;
                        FUNC_QUERY: state_next = ST_HOLE;
                        default: state_next = ST_OUT;
                    endcase
                end
            end
            ST_LOAD: if (ld_word_reg == 2'd3) state_next = ST_OUT;
            ST_HOLE: begin
                if (valid_reg[slot_reg]) state_next = ST_RD_D;
                else if (slot_reg == SLOT_W'(NUM_HOLES - 1)) state_next = ST_OUT;
            end
            ST_RD_D: state_next = ST_MUL;
            ST_MUL: begin
                if (term_phase_reg && term_reg == 2'd2) state_next = ST_ROW_END;
            end
            ST_ROW_END: begin
                if (acc > ONE || acc < -ONE) state_next = ST_DECIDE;
                else if (last_row) state_next = round_reg[slot_reg] ? ST_SQ : ST_DECIDE;
                else state_next = ST_RD_D;
            end
            ST_SQ: state_next = ST_SQ_ACC;
            ST_SQ_ACC: begin
                if (last_row) state_next = ST_DECIDE;
                else state_next = ST_SQ;
            end
            ST_DECIDE: begin
                if (!reject_reg && !(round_reg[slot_reg] && sq_sum > ONE_SQ))
                    state_next = ST_OUT;
                else if (slot_reg == SLOT_W'(NUM_HOLES - 1)) state_next = ST_OUT;
                else state_next = ST_HOLE;
            end
            ST_OUT: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath controls and multiplier operands
    logic signed [31:0] pt_sel;
    logic skip_term;
    always_comb begin
        case (term_reg)
            2'd0: pt_sel = px_reg;
            2'd1: pt_sel = py_reg;
            default: pt_sel = pz_reg;
        endcase
        skip_term = (term_reg == 2'd1) && !solid_cur;
        ctrl = '0;
        mul_a = $signed(rd_reg);
        mul_b = 34'(pt_sel);
        case (state_reg)
            ST_HOLE: ctrl.clr = 1'b1;
            ST_RD_D: ctrl.ld_d = 1'b1;
            ST_MUL: begin
                if (term_phase_reg && !skip_term) ctrl.ld_prod = 1'b1;
                if (skip_term) mul_b = '0;
            end
            ST_SQ: begin
                mul_a = 32'(comp_reg[row_reg]);
                mul_b = 34'(comp_reg[row_reg]);
            end
            ST_SQ_ACC: ctrl.sq_acc = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            valid_reg   <= '0;
            round_reg   <= '0;
            solid_reg   <= '0;
            m_valid_reg <= 1'b0;
            hit_reg     <= 1'b0;
            hit_slot_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (out_fire) m_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        slot_reg <= s_slot;
                        row_reg  <= (s_func == FUNC_LOAD) ? s_row : 2'd0;
                        px_reg <= s_point_x;
                        py_reg <= s_point_y;
                        pz_reg <= s_point_z;
                        hit_reg <= 1'b0;
                        hit_slot_reg <= '0;
                        ld_word_reg <= '0;
                        if (s_func == FUNC_QUERY) slot_reg <= '0;
                        if (s_func == FUNC_CLEAR) valid_reg <= '0;
                        if (s_func == FUNC_LOAD && s_row != 2'd3) begin
                            valid_reg[s_slot] <= 1'b1;
                            round_reg[s_slot] <= s_round_shape;
                            solid_reg[s_slot] <= s_solid_shape;
                        end
                    end
                end
                ST_LOAD: ld_word_reg <= ld_word_reg + 2'd1;
                ST_HOLE: begin
                    row_reg <= '0;
                    term_reg <= '0;
                    term_phase_reg <= 1'b0;
                    reject_reg <= 1'b0;
                    if (!valid_reg[slot_reg] && slot_reg != SLOT_W'(NUM_HOLES - 1))
                        slot_reg <= slot_reg + SLOT_W'(1);
                end
                ST_MUL: begin
                    term_phase_reg <= !term_phase_reg;
                    if (term_phase_reg) term_reg <= term_reg + 2'd1;
                end
                ST_ROW_END: begin
                    comp_reg[row_reg] <= acc;
                    term_reg <= '0;
                    if (acc > ONE || acc < -ONE) reject_reg <= 1'b1;
                    if (!(acc > ONE || acc < -ONE)) begin
                        if (last_row) begin
                            if (round_reg[slot_reg]) row_reg <= '0;
                        end else begin
                            row_reg <= row_reg + 2'd1;
                        end
                    end
                end
                ST_SQ_ACC: if (!last_row) row_reg <= row_reg + 2'd1;
                ST_DECIDE: begin
                    if (!reject_reg && !(round_reg[slot_reg] && sq_sum > ONE_SQ)) begin
                        hit_reg <= 1'b1;
                        hit_slot_reg <= slot_reg;
                    end else if (slot_reg != SLOT_W'(NUM_HOLES - 1)) begin
                        slot_reg <= slot_reg + SLOT_W'(1);
                    end
                end
                ST_OUT: m_valid_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_hit      = hit_reg;
    assign m_hit_slot = hit_slot_reg;

    `HPCT_ASSERT(a_no_accept_busy, aclk, aresetn, (state_reg != ST_IDLE) |-> !s_ready, "ready while busy")
    `HPCT_ASSERT(a_slot_zero_miss, aclk, aresetn, (m_valid && !m_hit) |-> (m_hit_slot == '0), "miss with nonzero slot")
    `HPCT_ASSERT(a_out_hold, aclk, aresetn, (m_valid && !m_ready) |=> m_valid, "result dropped")
endmodule

// ===== tb/tb_hole_point_containment_test.sv =====
module tb_hole_point_containment_test;
    import hpct_pkg::*;

    localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

    typedef struct {
        func_t             func;
        logic [3:0]        slot;
        logic [1:0]        row;
        logic signed [31:0] a, b, c, d;
        logic              rnd, sld;
        logic signed [31:0] x, y, z;
        logic              known;
        logic              e_hit;
        logic [3:0]        e_slot;
    } txn_t;

    typedef struct {
        logic       hit;
        logic [3:0] slot;
    } outcome_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [1:0] s_func = '0;
    logic [3:0] s_slot = '0;
    logic [1:0] s_row = '0;
    logic signed [31:0] s_coef_a = '0, s_coef_b = '0, s_coef_c = '0, s_coef_d = '0;
    logic s_round_shape = 1'b0, s_solid_shape = 1'b0;
    logic signed [31:0] s_point_x = '0, s_point_y = '0, s_point_z = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_hit;
    logic [3:0] m_hit_slot;

    logic signed [31:0] hole_coef [NUM_HOLES][ROWS][4];
    logic [ROWS-1:0] row_written [NUM_HOLES];
    logic [NUM_HOLES-1:0] hole_valid, hole_round, hole_solid;

    outcome_t pending_outcomes[$];
    int errors = 0;
    int stall_left = 0;
    txn_t directed[$];

    hole_point_containment_test dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #200_000_000;
        $display("tb_hole_point_containment_test: FAIL");
        $finish;
    end

    function automatic longint floor_q(longint v);
        return v >>> FRAC_BITS;
    endfunction

    function automatic logic hole_hit(int h, longint x, longint y, longint z);
        longint one, comp, sq;
        int used;
        one = longint'(1) << FRAC_BITS;
        used = hole_solid[h] ? 3 : 2;
        sq = 0;
        for (int r = 0; r < used; r++) begin
            comp = longint'(hole_coef[h][r][3]) + floor_q(longint'(hole_coef[h][r][0]) * x)
                 + floor_q(longint'(hole_coef[h][r][2]) * z);
            if (hole_solid[h])
                comp += floor_q(longint'(hole_coef[h][r][1]) * y);
            if (comp > one || comp < -one)
                return 1'b0;
            sq += comp * comp;
        end
        return !(hole_round[h] && sq > one * one);
    endfunction

    function automatic outcome_t apply_transaction(txn_t t);
        outcome_t o;
        o.hit = 1'b0;
        o.slot = '0;
        case (t.func)
            FUNC_CLEAR: hole_valid = '0;
            FUNC_LOAD: begin
                if (t.row < ROWS) begin
                    hole_coef[t.slot][t.row][0] = t.a;
                    hole_coef[t.slot][t.row][1] = t.b;
                    hole_coef[t.slot][t.row][2] = t.c;
                    hole_coef[t.slot][t.row][3] = t.d;
                    row_written[t.slot][t.row] = 1'b1;
                    hole_valid[t.slot] = 1'b1;
                    hole_round[t.slot] = t.rnd;
                    hole_solid[t.slot] = t.sld;
                end
            end
            FUNC_QUERY: begin
                for (int h = 0; h < NUM_HOLES; h++) begin
                    if (hole_valid[h] && hole_hit(h, t.x, t.y, t.z)) begin
                        o.hit = 1'b1;
                        o.slot = h[3:0];
                        break;
                    end
                end
            end
            default: ;
        endcase
        return o;
    endfunction

    function automatic logic query_safe();
        for (int h = 0; h < NUM_HOLES; h++)
            if (hole_valid[h] && row_written[h] != 3'b111)
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic logic signed [31:0] rand_word(int scale);
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return Q_ONE;
            2: return -Q_ONE;
            default: return $signed($urandom_range(0, 2 * scale)) - scale;
        endcase
    endfunction

    function automatic int rand_gap();
        int k;
        k = $urandom_range(0, 99);
        if (k < 40) return 0;
        if (k < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic txn_t blank_txn(func_t f);
        txn_t t;
        t.func = f; t.slot = '0; t.row = '0;
        t.a = '0; t.b = '0; t.c = '0; t.d = '0;
        t.rnd = 1'b0; t.sld = 1'b0;
        t.x = '0; t.y = '0; t.z = '0;
        t.known = 1'b0; t.e_hit = 1'b0; t.e_slot = '0;
        return t;
    endfunction

    function automatic txn_t load_txn(int sl, int rw, logic signed [31:0] a, b, c, d,
                                      logic rnd, logic sld);
        txn_t t;
        t = blank_txn(FUNC_LOAD);
        t.slot = 4'(sl); t.row = 2'(rw); t.a = a; t.b = b; t.c = c; t.d = d;
        t.rnd = rnd; t.sld = sld;
        t.known = 1'b1;
        return t;
    endfunction

    function automatic txn_t query_txn(logic signed [31:0] x, y, z);
        txn_t t;
        t = blank_txn(FUNC_QUERY);
        t.x = x; t.y = y; t.z = z;
        return t;
    endfunction

    function automatic void add_row(txn_t t);
        directed = {directed, t};
    endfunction

    task automatic send(txn_t t);
        outcome_t o;
        if (t.func == FUNC_QUERY && !query_safe())
            return;
        repeat (rand_gap()) @(negedge aclk);
        s_func = t.func; s_slot = t.slot; s_row = t.row;
        s_coef_a = t.a; s_coef_b = t.b; s_coef_c = t.c; s_coef_d = t.d;
        s_round_shape = t.rnd; s_solid_shape = t.sld;
        s_point_x = t.x; s_point_y = t.y; s_point_z = t.z;
        s_valid = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        o = apply_transaction(t);
        if (t.known && (o.hit !== t.e_hit || o.slot !== t.e_slot)) begin
            $display("%0t predictor disagrees with table: exp %0b/%0d got %0b/%0d",
                     $time, t.e_hit, t.e_slot, o.hit, o.slot);
            errors++;
        end
        pending_outcomes = {pending_outcomes, o};
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic load_hole(int sl, logic rnd, logic sld, int scale);
        for (int r = 0; r < ROWS; r++)
            send(load_txn(sl, r, rand_word(scale), rand_word(scale), rand_word(scale),
                          rand_word(scale), rnd, sld));
    endtask

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 49) == 0) begin
            stall_left = $urandom_range(10, 60);
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 9) < 7);
        end
    end

    always @(posedge aclk) begin
        outcome_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_outcomes.size() == 0) begin
                $display("%0t unexpected result hit=%0b slot=%0d", $time, m_hit, m_hit_slot);
                errors++;
            end else begin
                e = pending_outcomes.pop_front();
                if (m_hit !== e.hit) begin
                    $display("%0t hit mismatch: exp %0b got %0b", $time, e.hit, m_hit);
                    errors++;
                end
                if (m_hit_slot !== e.slot) begin
                    $display("%0t hit_slot mismatch: exp %0d got %0d",
                             $time, e.slot, m_hit_slot);
                    errors++;
                end
            end
        end
    end

    initial begin
        txn_t t;
        int sl, k;
        for (int h = 0; h < NUM_HOLES; h++)
            row_written[h] = '0;
        hole_valid = '0; hole_round = '0; hole_solid = '0;

        t = query_txn(32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff);
        t.known = 1'b1; add_row(t);
        t = blank_txn(FUNC_NOP); t.known = 1'b1; t.slot = 4'hf; t.row = 2'd3;
        t.a = 32'sh8000_0000; t.b = 32'sh7fff_ffff; t.c = -1; t.d = -1;
        t.rnd = 1'b1; t.sld = 1'b1; t.x = -1; t.y = -1; t.z = -1;
        add_row(t);
        add_row(load_txn(15, 3, -1, -1, -1, -1, 1'b1, 1'b1));
        // unit box in slot 15, flat
        add_row(load_txn(15, 0, Q_ONE, 32'sh7fff_ffff, 0, 0, 1'b0, 1'b0));
        add_row(load_txn(15, 1, 0, 32'sh8000_0000, Q_ONE, 0, 1'b0, 1'b0));
        add_row(load_txn(15, 2, 0, 0, 0, 0, 1'b0, 1'b0));
        add_row(query_txn(Q_ONE, 32'sh7fff_ffff, -Q_ONE));
        add_row(query_txn(Q_ONE + 1, 0, 0));
        // round solid unit sphere in slot 0
        add_row(load_txn(0, 0, Q_ONE, 0, 0, 0, 1'b1, 1'b1));
        add_row(load_txn(0, 1, 0, Q_ONE, 0, 0, 1'b1, 1'b1));
        add_row(load_txn(0, 2, 0, 0, Q_ONE, 0, 1'b1, 1'b1));
        add_row(query_txn(Q_ONE, 0, 0));
        add_row(query_txn(32'sh0000_c000, 32'sh0000_c000, 0));
        add_row(query_txn(0, -Q_ONE - 1, 0));
        add_row(query_txn(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
        t = blank_txn(FUNC_CLEAR); t.known = 1'b1; add_row(t);
        t = query_txn(0, 0, 0); t.known = 1'b1; add_row(t);
        add_row(load_txn(0, 2, -1, -1, -1, 32'sh7fff_ffff, 1'b0, 1'b1));

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (directed[i]) send(directed[i]);

        // write every row once, then drop all holes
        for (int h = 0; h < NUM_HOLES; h++)
            load_hole(h, 1'($urandom), 1'($urandom), 32'h2_0000);
        send(blank_txn(FUNC_CLEAR));

        for (int n = 0; n < 850; n++) begin
            k = $urandom_range(0, 99);
            sl = $urandom_range(0, NUM_HOLES - 1);
            if (n == 400) begin
                while (pending_outcomes.size() != 0) @(negedge aclk);
            end
            if (k < 3) begin
                send(blank_txn(FUNC_CLEAR));
            end else if (k < 5) begin
                t = blank_txn(FUNC_NOP);
                t.slot = 4'($urandom); t.row = 2'($urandom);
                t.a = $urandom; t.x = $urandom;
                send(t);
            end else if (k < 20) begin
                load_hole(sl, 1'($urandom), 1'($urandom),
                          $urandom_range(0, 1) ? 32'h2_0000 : 32'h200);
                n += 2;
            end else if (k < 30) begin
                t = load_txn(sl, $urandom, $urandom, $urandom, $urandom, $urandom,
                             1'($urandom), 1'($urandom));
                send(t);
            end else if (k < 90) begin
                send(query_txn(rand_word(32'h1_8000), rand_word(32'h1_8000),
                               rand_word(32'h1_8000)));
            end else begin
                send(query_txn($urandom, $urandom, $urandom));
            end
        end

        while (pending_outcomes.size() != 0) @(negedge aclk);
        repeat (500) @(negedge aclk);
        if (errors == 0 && pending_outcomes.size() == 0)
            $display("tb_hole_point_containment_test: PASS");
        else
            $display("tb_hole_point_containment_test: FAIL");
        $finish;
    end
endmodule
